/* rtl/core/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
// No dependencies; imported by bcc_gesture and button_click_classifier.

package bcc_pkg;

  // Width of the configuration registers and of the write data port
  localparam int CFG_W = 16;
  // Width of the configuration register index
  localparam int CFG_IDX_W = 1;
  // Default width of the hold and since-release counters
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd300;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd40;

  localparam logic [1:0] CLICK_MAX = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 1'b0,
    CFG_DOUBLE_CLICK = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } event_code_t;

  // One classified gesture, handed from the gesture core to the output register
  typedef struct packed {
    logic        valid;
    event_code_t code;
  } gesture_ev_t;

endpackage

/* rtl/core/bcc_gesture.sv */
// Gesture state and per-tick classification logic.
// Depends on bcc_pkg for thresholds, click limit and event codes.

module bcc_gesture #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic                      pressed,
  input  logic [bcc_pkg::CFG_W-1:0] long_press_ticks,
  input  logic [bcc_pkg::CFG_W-1:0] double_click_ticks,
  output bcc_pkg::gesture_ev_t      ev
);

  import bcc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic                   was_pressed_r, was_pressed_nxt;
  logic                   long_done_r, long_done_nxt;
  logic [1:0]             clicks_r, clicks_nxt;
  logic [COUNT_WIDTH-1:0] hold_r, hold_nxt;
  logic [COUNT_WIDTH-1:0] since_r, since_nxt;

  logic                   press_edge;
  logic                   release_short;
  logic                   long_done_a;
  logic [COUNT_WIDTH-1:0] since_inc;
  logic [1:0]             clicks_b;
  logic [COUNT_WIDTH-1:0] since_b;
  logic                   fire_long;
  logic                   fire_click;
  logic [CMP_W-1:0]       hold_cmp, long_cmp, since_cmp, dbl_cmp;

  always_comb begin
    press_edge = pressed && !was_pressed_r;

    if (press_edge) begin
      hold_nxt = '0;
    end else if (pressed && hold_r != '1) begin
      hold_nxt = hold_r + 1'b1;
    end else begin
      hold_nxt = hold_r;
    end
    long_done_a = press_edge ? 1'b0 : long_done_r;
    since_inc   = (since_r == '1) ? since_r : since_r + 1'b1;

    hold_cmp  = CMP_W'(hold_nxt);
    long_cmp  = CMP_W'(long_press_ticks);
    fire_long = pressed && !long_done_a && (hold_cmp >= long_cmp);

    // a short release only happens with the pin up, so a long fire never coincides
    release_short = !pressed && was_pressed_r && !long_done_a;
    if (release_short) begin
      clicks_b = (clicks_r != CLICK_MAX) ? clicks_r + 1'b1 : clicks_r;
      since_b  = '0;
    end else begin
      clicks_b = fire_long ? 2'd0 : clicks_r;
      since_b  = since_inc;
    end

    since_cmp  = CMP_W'(since_b);
    dbl_cmp    = CMP_W'(double_click_ticks);
    fire_click = (clicks_b != 2'd0) && (since_cmp > dbl_cmp) && !fire_long;

    clicks_nxt      = fire_click ? 2'd0 : clicks_b;
    since_nxt       = since_b;
    long_done_nxt   = long_done_a || fire_long;
    was_pressed_nxt = pressed;

    ev.valid = fire_long || fire_click;
    if (fire_long) begin
      ev.code = EV_LONG;
    end else if (clicks_b >= 2'd2) begin
      ev.code = EV_DOUBLE;
    end else begin
      ev.code = EV_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      long_done_r   <= 1'b0;
      clicks_r      <= 2'd0;
      hold_r        <= '0;
      since_r       <= '0;
    end else if (step_en) begin
      was_pressed_r <= was_pressed_nxt;
      long_done_r   <= long_done_nxt;
      clicks_r      <= clicks_nxt;
      hold_r        <= hold_nxt;
      since_r       <= since_nxt;
    end
  end

endmodule

/* rtl/core/button_click_classifier.sv */
// Button gesture classifier: single, double and long-press events from pin samples.
// Pipeline: input register, then result register. Throughput: one sample beat per
// cycle unless stalled; the gesture counters update once per beat.
// Reset (rst_n low, synchronous): thresholds return to 300 and 40 ticks, gesture
// state clears to released with no pending clicks, both pipeline stages empty.
// Depends on bcc_pkg and bcc_gesture.

module button_click_classifier #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_code,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);

  import bcc_pkg::*;

  logic [CFG_W-1:0] long_press_r;
  logic [CFG_W-1:0] double_click_r;

  logic             s1_valid_r;
  logic             s1_pin_r;
  logic             out_valid_r;
  event_code_t      out_code_r;

  logic             advance;
  logic             in_take;
  gesture_ev_t      ev;

  // stage 1 moves on when the result slot is empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LONG_PRESS_RST;
      double_click_r <= DOUBLE_CLICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LONG_PRESS:   long_press_r   <= cfg_data;
        CFG_DOUBLE_CLICK: double_click_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r <= in_pin_level;
    end
  end

  bcc_gesture #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_gesture (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (s1_valid_r && advance),
    .pressed            (!s1_pin_r),
    .long_press_ticks   (long_press_r),
    .double_click_ticks (double_click_r),
    .ev                 (ev)
  );

  // load a result only when stage 1 holds a beat that produced an event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && ev.valid) begin
      out_code_r <= ev.code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for button_click_classifier: pin samples in, gesture events out.
// Predicts single, double and long-press events per sample and checks each result beat.
// Depends on bcc_pkg and the button_click_classifier RTL.
`timescale 1ns / 1ps

module testbench;
  import bcc_pkg::*;

  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_pin_level = 1'b1;
  logic                 out_stall = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           out_event_code;

  // gesture predictor state and thresholds
  logic [CFG_W-1:0] long_thr = LONG_PRESS_RST;
  logic [CFG_W-1:0] dbl_thr = DOUBLE_CLICK_RST;
  logic             was_down = 1'b0;
  logic             long_seen = 1'b0;
  logic [1:0]       taps_pending = 2'd0;
  logic [CNT_W-1:0] hold_cnt = '0;
  logic [CNT_W-1:0] since_cnt = '0;

  event_code_t expected_events[$];
  int          error_count = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          holdoff_req = 1'b0;
  bit          holdoff_seen = 1'b0;
  int          holdoff_left = 0;

  button_click_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pin_level   (in_pin_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("button_click_classifier test failed");
    $finish;
  end

  function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  // advance the gesture state by one sample tick, queue the event it causes
  task automatic classify_tick(input logic lvl);
    logic pressed;
    logic fired;
    pressed = ~lvl;
    fired = 1'b0;
    if (pressed && !was_down) begin
      hold_cnt = '0;
      long_seen = 1'b0;
    end else if (pressed) begin
      hold_cnt = sat_up(hold_cnt);
    end
    since_cnt = sat_up(since_cnt);
    if (pressed && !long_seen && hold_cnt >= long_thr) begin
      long_seen = 1'b1;
      taps_pending = 2'd0;
      expected_events.push_back(EV_LONG);
      fired = 1'b1;
    end
    if (!pressed && was_down && !long_seen) begin
      if (taps_pending < CLICK_MAX) taps_pending = taps_pending + 1'b1;
      since_cnt = '0;
    end
    if (taps_pending != 2'd0 && since_cnt > dbl_thr && !fired) begin
      expected_events.push_back((taps_pending >= 2'd2) ? EV_DOUBLE : EV_SINGLE);
      taps_pending = 2'd0;
    end
    was_down = pressed;
  endtask

  task automatic check_event(input logic [1:0] got);
    event_code_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event beat, expected none, actual %0d", $time, got);
      error_count++;
    end else begin
      want = expected_events.pop_front();
      if (got !== want) begin
        $display("%0t: event_code mismatch, expected %0d, actual %0d", $time, want, got);
        error_count++;
      end
    end
  endtask

  // result side: check accepted beats, stall at random or hold off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_event(out_event_code);
    if (holdoff_req && !holdoff_seen) holdoff_left = 300;
    holdoff_seen = holdoff_req;
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on && ($urandom_range(99) < 7);
    end
  end

  task automatic send_level(input logic lvl);
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_level <= lvl;
    do @(posedge clk); while (in_stall);
    classify_tick(lvl);
  endtask

  task automatic hold_pin(input logic lvl, input int n);
    repeat (n) send_level(lvl);
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic wait_idle;
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LONG_PRESS) long_thr = val;
    else dbl_thr = val;
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dc);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_DOUBLE_CLICK, dc);
  endtask

  task automatic test_reset_values;
    hold_pin(1'b0, 3);
    hold_pin(1'b1, 42);
    hold_pin(1'b0, 302);
    hold_pin(1'b1, 5);
  endtask

  task automatic test_clicks;
    set_thresholds(16'd4, 16'd3);
    hold_pin(1'b0, 2);
    hold_pin(1'b1, 6);
    repeat (2) begin
      hold_pin(1'b0, 1);
      hold_pin(1'b1, 2);
    end
    hold_pin(1'b1, 4);
    // four clicks saturate the count at three and still report double
    repeat (4) begin
      hold_pin(1'b0, 2);
      hold_pin(1'b1, 1);
    end
    hold_pin(1'b1, 5);
  endtask

  task automatic test_long_press;
    hold_pin(1'b0, 7);
    hold_pin(1'b1, 6);
    // pending click times out and reports single before the long press fires
    hold_pin(1'b0, 1);
    hold_pin(1'b1, 1);
    hold_pin(1'b0, 6);
    hold_pin(1'b1, 6);
  endtask

  task automatic test_zero_thresholds;
    set_thresholds(16'd0, 16'd0);
    hold_pin(1'b0, 2);
    hold_pin(1'b1, 2);
    hold_pin(1'b0, 1);
    hold_pin(1'b1, 1);
    write_reg(CFG_LONG_PRESS, 16'd1);
    hold_pin(1'b0, 1);
    hold_pin(1'b1, 3);
  endtask

  task automatic test_slow_second_press;
    set_thresholds(16'd10, 16'd3);
    hold_pin(1'b0, 2);
    hold_pin(1'b1, 1);
    hold_pin(1'b0, 6);
    hold_pin(1'b1, 6);
  endtask

  task automatic test_wide_thresholds;
    set_thresholds(16'hFFFF, 16'hFFFF);
    hold_pin(1'b0, 2);
    hold_pin(1'b1, 2);
    hold_pin(1'b0, 12);
    hold_pin(1'b1, 3);
    // clicks that the widest window never reports until the window shrinks
    hold_pin(1'b0, 3);
    hold_pin(1'b1, 20);
    write_reg(CFG_DOUBLE_CLICK, 16'd5);
    hold_pin(1'b1, 3);
  endtask

  task automatic test_backpressure;
    set_thresholds(16'd0, 16'hFFFF);
    holdoff_req = 1'b1;
    repeat (30) begin
      send_level(1'b0);
      send_level(1'b1);
    end
    holdoff_req = 1'b0;
  endtask

  task automatic test_random;
    int sent;
    int n;
    int lim_p;
    int lim_r;
    int quota;
    for (int phase = 0; phase < 5; phase++) begin
      set_thresholds(($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                              : 16'($urandom_range(24)),
                     ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                              : 16'($urandom_range(16)));
      idle_on = (phase != 1);
      stall_on = (phase != 1);
      quota = (phase == 1) ? 100 : 25;
      lim_p = (long_thr > 37) ? 40 : long_thr + 3;
      lim_r = (dbl_thr > 27) ? 30 : dbl_thr + 3;
      sent = 0;
      while (sent < quota) begin
        if ($urandom_range(4) == 0) begin
          n = $urandom_range(12, 1);
          repeat (n) send_level(1'($urandom_range(1)));
          sent += n;
        end else begin
          repeat ($urandom_range(4, 1)) begin
            n = $urandom_range(lim_p, 1);
            hold_pin(1'b0, n);
            sent += n;
            n = $urandom_range(lim_r, 1);
            hold_pin(1'b1, n);
            sent += n;
          end
          n = $urandom_range(lim_r + 10, 1);
          hold_pin(1'b1, n);
          sent += n;
        end
      end
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_clicks();
    test_long_press();
    test_zero_thresholds();
    test_slow_second_press();
    test_wide_thresholds();
    test_backpressure();
    test_random();
    wait_idle();
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("button_click_classifier test passed");
    end else begin
      $display("button_click_classifier test failed");
    end
    $finish;
  end

endmodule
